@@ rtl/core/kwmq_pkg.sv @@
// Package for the k-way merge sorted queue: command and status codes,
// the per-cycle chain operation and the shared field widths.
// Used by kwmq_cell and kway_merge_sorted_queue; depends on nothing.
package kwmq_pkg;

   // Fixed field widths.
   localparam int VALUE_BITS  = 32;
   localparam int LIST_BITS   = 5;
   localparam int CMD_BITS    = 2;
   localparam int STATUS_BITS = 2;

   // Parameter defaults for the top level.
   localparam int QUEUE_DEPTH_DEFAULT = 32;
   localparam int INDEX_BITS_DEFAULT  = 16;

   // Command codes on req_cmd.
   localparam logic [CMD_BITS-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_POP    = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_DUMP   = 2'd2;

   // Result status codes.
   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // Operation that every cell of the chain performs.
   typedef enum logic [1:0] {
      OP_HOLD,
      OP_INSERT,
      OP_POP,
      OP_ROTATE
   } op_type;

   // Control broadcast from the sequencer to all cells.
   typedef struct packed {
      op_type                 op;
      logic [VALUE_BITS-1:0]  new_value;
      logic [LIST_BITS-1:0]   new_list;
   } chain_ctrl_type;

endpackage

@@ rtl/core/kwmq_cell.sv @@
// One cell of the sorted chain: holds a single entry and its valid bit.
// Depends on kwmq_pkg for the operation code and control struct.
module kwmq_cell #(
   parameter int INDEX_BITS = kwmq_pkg::INDEX_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  kwmq_pkg::chain_ctrl_type              ctrl,
   input  logic [INDEX_BITS-1:0]                 new_index,
   // Neighbor toward the head (smaller keys).
   input  logic                                  prev_valid,
   input  logic                                  prev_gt,
   input  logic [kwmq_pkg::VALUE_BITS-1:0]       prev_value,
   input  logic [kwmq_pkg::LIST_BITS-1:0]        prev_list,
   input  logic [INDEX_BITS-1:0]                 prev_index,
   // Neighbor toward the tail (larger keys).
   input  logic                                  next_valid,
   input  logic [kwmq_pkg::VALUE_BITS-1:0]       next_value,
   input  logic [kwmq_pkg::LIST_BITS-1:0]        next_list,
   input  logic [INDEX_BITS-1:0]                 next_index,
   // Head of the chain, fed back to the tail during a rotation.
   input  logic [kwmq_pkg::VALUE_BITS-1:0]       head_value,
   input  logic [kwmq_pkg::LIST_BITS-1:0]        head_list,
   input  logic [INDEX_BITS-1:0]                 head_index,
   output logic                                  valid,
   output logic                                  gt,
   output logic [kwmq_pkg::VALUE_BITS-1:0]       value,
   output logic [kwmq_pkg::LIST_BITS-1:0]        list,
   output logic [INDEX_BITS-1:0]                 index
);

   logic                                valid_ff, valid_in;
   logic [kwmq_pkg::VALUE_BITS-1:0]     value_ff, value_in;
   logic [kwmq_pkg::LIST_BITS-1:0]      list_ff, list_in;
   logic [INDEX_BITS-1:0]               index_ff, index_in;
   logic                                take_new;
   logic                                take_prev;

   // The stored key is strictly greater than the key being inserted.
   assign gt = valid_ff && ($signed(value_ff) > $signed(ctrl.new_value));

   // The new entry lands in the first cell whose key is greater, or in the
   // first empty cell; every greater entry moves one cell toward the tail.
   assign take_new  = prev_valid && !prev_gt && (!valid_ff || gt);
   assign take_prev = prev_gt;

   // Next-state selection for the held entry.
   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      list_in  = list_ff;
      index_in = index_ff;
      unique case (ctrl.op)
         kwmq_pkg::OP_INSERT: begin
            if (take_prev) begin
               valid_in = 1'b1;
               value_in = prev_value;
               list_in  = prev_list;
               index_in = prev_index;
            end else if (take_new) begin
               valid_in = 1'b1;
               value_in = ctrl.new_value;
               list_in  = ctrl.new_list;
               index_in = new_index;
            end
         end
         kwmq_pkg::OP_POP: begin
            valid_in = next_valid;
            value_in = next_value;
            list_in  = next_list;
            index_in = next_index;
         end
         kwmq_pkg::OP_ROTATE: begin
            if (next_valid) begin
               value_in = next_value;
               list_in  = next_list;
               index_in = next_index;
            end else if (valid_ff) begin
               value_in = head_value;
               list_in  = head_list;
               index_in = head_index;
            end
         end
         default: begin
            valid_in = valid_ff;
         end
      endcase
   end

   // Valid bit is cleared by reset; the payload needs no reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
      list_ff  <= list_in;
      index_ff <= index_in;
   end

   assign valid = valid_ff;
   assign value = value_ff;
   assign list  = list_ff;
   assign index = index_ff;

endmodule

@@ rtl/core/kway_merge_sorted_queue.sv @@
// Sorted queue for a k-way merge. For insert and pop the result strobes in
// the cycle after the transfer and busy stays low, so one command can
// follow every cycle. A dump of N entries gives N results back to back, one
// per step of the cell chain, with busy high while the results after the
// first are emitted. Results cannot be stalled. Reset empties the queue by
// clearing every cell's valid bit and the entry count.
// Depends on kwmq_pkg and kwmq_cell.
module kway_merge_sorted_queue #(
   parameter int QUEUE_DEPTH = kwmq_pkg::QUEUE_DEPTH_DEFAULT,
   parameter int INDEX_BITS  = kwmq_pkg::INDEX_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [kwmq_pkg::CMD_BITS-1:0]       req_cmd,
   input  logic signed [kwmq_pkg::VALUE_BITS-1:0] req_value,
   input  logic [kwmq_pkg::LIST_BITS-1:0]      req_source_list,
   input  logic [INDEX_BITS-1:0]               req_element_index,
   output logic                                rsp_valid,
   output logic signed [kwmq_pkg::VALUE_BITS-1:0] rsp_out_value,
   output logic [kwmq_pkg::LIST_BITS-1:0]      rsp_out_list,
   output logic [INDEX_BITS-1:0]               rsp_out_index,
   output logic [kwmq_pkg::STATUS_BITS-1:0]    rsp_status,
   output logic                                rsp_last
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic                            valid_w [QUEUE_DEPTH];
   logic                            gt_w    [QUEUE_DEPTH];
   logic [kwmq_pkg::VALUE_BITS-1:0] value_w [QUEUE_DEPTH];
   logic [kwmq_pkg::LIST_BITS-1:0]  list_w  [QUEUE_DEPTH];
   logic [INDEX_BITS-1:0]           index_w [QUEUE_DEPTH];

   kwmq_pkg::chain_ctrl_type        ctrl;
   logic                            accept;
   logic                            full;
   logic                            empty;

   logic [CW-1:0]                   count_ff, count_in;
   logic [CW-1:0]                   remain_ff, remain_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [kwmq_pkg::VALUE_BITS-1:0] rsp_value_ff, rsp_value_in;
   logic [kwmq_pkg::LIST_BITS-1:0]  rsp_list_ff, rsp_list_in;
   logic [INDEX_BITS-1:0]           rsp_index_ff, rsp_index_in;
   kwmq_pkg::status_type            rsp_status_ff, rsp_status_in;
   logic                            rsp_last_ff, rsp_last_in;

   assign busy   = (remain_ff != '0);
   assign accept = start && !busy;
   assign full   = (count_ff == CW'(QUEUE_DEPTH));
   assign empty  = (count_ff == '0);

   // Row of cells; cell 0 holds the smallest key.
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic                            p_valid, p_gt, n_valid;
      logic [kwmq_pkg::VALUE_BITS-1:0] p_value, n_value;
      logic [kwmq_pkg::LIST_BITS-1:0]  p_list, n_list;
      logic [INDEX_BITS-1:0]           p_index, n_index;

      if (i == 0) begin : g_head
         assign p_valid = 1'b1;
         assign p_gt    = 1'b0;
         assign p_value = '0;
         assign p_list  = '0;
         assign p_index = '0;
      end else begin : g_body
         assign p_valid = valid_w[i-1];
         assign p_gt    = gt_w[i-1];
         assign p_value = value_w[i-1];
         assign p_list  = list_w[i-1];
         assign p_index = index_w[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign n_valid = 1'b0;
         assign n_value = '0;
         assign n_list  = '0;
         assign n_index = '0;
      end else begin : g_inner
         assign n_valid = valid_w[i+1];
         assign n_value = value_w[i+1];
         assign n_list  = list_w[i+1];
         assign n_index = index_w[i+1];
      end

      kwmq_cell #(
         .INDEX_BITS (INDEX_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .new_index  (req_element_index),
         .prev_valid (p_valid),
         .prev_gt    (p_gt),
         .prev_value (p_value),
         .prev_list  (p_list),
         .prev_index (p_index),
         .next_valid (n_valid),
         .next_value (n_value),
         .next_list  (n_list),
         .next_index (n_index),
         .head_value (value_w[0]),
         .head_list  (list_w[0]),
         .head_index (index_w[0]),
         .valid      (valid_w[i]),
         .gt         (gt_w[i]),
         .value      (value_w[i]),
         .list       (list_w[i]),
         .index      (index_w[i])
      );
   end

   // Command decode, chain operation, count and response next values.
   always_comb begin
      ctrl.op        = kwmq_pkg::OP_HOLD;
      ctrl.new_value = req_value;
      ctrl.new_list  = req_source_list;
      count_in       = count_ff;
      remain_in      = remain_ff;
      rsp_valid_in   = 1'b0;
      rsp_value_in   = '0;
      rsp_list_in    = '0;
      rsp_index_in   = '0;
      rsp_status_in  = kwmq_pkg::ST_OK;
      rsp_last_in    = 1'b1;
      if (busy) begin
         // Dump in progress: emit the head and rotate the chain by one.
         ctrl.op      = kwmq_pkg::OP_ROTATE;
         remain_in    = remain_ff - 1'b1;
         rsp_valid_in = 1'b1;
         rsp_value_in = value_w[0];
         rsp_list_in  = list_w[0];
         rsp_index_in = index_w[0];
         rsp_last_in  = (remain_ff == CW'(1));
      end else if (accept) begin
         unique case (req_cmd)
            kwmq_pkg::CMD_INSERT: begin
               rsp_valid_in = 1'b1;
               if (full) begin
                  rsp_status_in = kwmq_pkg::ST_FULL;
               end else begin
                  ctrl.op  = kwmq_pkg::OP_INSERT;
                  count_in = count_ff + 1'b1;
               end
            end
            kwmq_pkg::CMD_POP: begin
               rsp_valid_in = 1'b1;
               if (empty) begin
                  rsp_status_in = kwmq_pkg::ST_EMPTY;
               end else begin
                  ctrl.op      = kwmq_pkg::OP_POP;
                  count_in     = count_ff - 1'b1;
                  rsp_value_in = value_w[0];
                  rsp_list_in  = list_w[0];
                  rsp_index_in = index_w[0];
               end
            end
            kwmq_pkg::CMD_DUMP: begin
               rsp_valid_in = 1'b1;
               if (empty) begin
                  rsp_status_in = kwmq_pkg::ST_EMPTY;
               end else begin
                  ctrl.op      = kwmq_pkg::OP_ROTATE;
                  remain_in    = count_ff - 1'b1;
                  rsp_value_in = value_w[0];
                  rsp_list_in  = list_w[0];
                  rsp_index_in = index_w[0];
                  rsp_last_in  = (count_ff == CW'(1));
               end
            end
            default: begin
               rsp_valid_in = 1'b0;
            end
         endcase
      end
   end

   // Control state and registered response.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_value_ff  <= rsp_value_in;
      rsp_list_ff   <= rsp_list_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_out_list  = rsp_list_ff;
   assign rsp_out_index = rsp_index_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

@@ tb/tb_kway_merge_sorted_queue.sv @@
// Self-checking testbench for kway_merge_sorted_queue: directed corner cases,
// then random fill, drain and mixed merge traffic with random sender gaps.
// Depends on kwmq_pkg and the kway_merge_sorted_queue RTL.
module tb_kway_merge_sorted_queue;

   localparam int DEPTH          = kwmq_pkg::QUEUE_DEPTH_DEFAULT;
   localparam int IDX            = kwmq_pkg::INDEX_BITS_DEFAULT;
   localparam int VW             = kwmq_pkg::VALUE_BITS;
   localparam int LW             = kwmq_pkg::LIST_BITS;
   localparam int CW             = kwmq_pkg::CMD_BITS;
   localparam int SW             = kwmq_pkg::STATUS_BITS;
   localparam int RANDOM_ITEMS   = 400;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = DEPTH + 8;
   localparam logic [CW-1:0] CMD_UNUSED = 2'd3;

   typedef struct {
      logic signed [VW-1:0] value;
      logic [LW-1:0]        list;
      logic [IDX-1:0]       index;
   } queue_entry_type;

   typedef struct {
      queue_entry_type  data;
      logic [SW-1:0]    status;
      logic             last;
   } queue_result_type;

   // Shadow copy of the sorted queue plus the results it still owes.
   class sorted_queue_shadow;
      queue_entry_type  store[$];
      queue_result_type owed[$];
      int mismatches;
      int results_checked;
      int insert_count;
      int pop_count;
      int dump_count;
      int ignored_count;
      int full_seen;
      int empty_seen;

      function int pending();
         return owed.size();
      endfunction

      function void owe(queue_entry_type e, logic [SW-1:0] st, logic fin);
         queue_result_type r;
         r.data   = e;
         r.status = st;
         r.last   = fin;
         owed.push_back(r);
      endfunction

      // Update the shadow queue for one accepted command and queue its results.
      function void apply_command(logic [CW-1:0] cmd,
                                  logic signed [VW-1:0] value,
                                  logic [LW-1:0] list,
                                  logic [IDX-1:0] index);
         queue_entry_type blank;
         queue_entry_type e;
         int pos;
         blank.value = '0;
         blank.list  = '0;
         blank.index = '0;
         case (cmd)
            kwmq_pkg::CMD_INSERT: begin
               insert_count++;
               if (store.size() >= DEPTH) begin
                  full_seen++;
                  owe(blank, kwmq_pkg::ST_FULL, 1'b1);
               end else begin
                  e.value = value;
                  e.list  = list;
                  e.index = index;
                  // Equal keys stay behind the ones already queued.
                  pos = store.size();
                  while (pos > 0 && store[pos-1].value > value) pos--;
                  store.insert(pos, e);
                  owe(blank, kwmq_pkg::ST_OK, 1'b1);
               end
            end
            kwmq_pkg::CMD_POP: begin
               pop_count++;
               if (store.size() == 0) begin
                  empty_seen++;
                  owe(blank, kwmq_pkg::ST_EMPTY, 1'b1);
               end else begin
                  owe(store[0], kwmq_pkg::ST_OK, 1'b1);
                  store.delete(0);
               end
            end
            kwmq_pkg::CMD_DUMP: begin
               dump_count++;
               if (store.size() == 0) begin
                  empty_seen++;
                  owe(blank, kwmq_pkg::ST_EMPTY, 1'b1);
               end else begin
                  foreach (store[i]) owe(store[i], kwmq_pkg::ST_OK, i == store.size() - 1);
               end
            end
            default: ignored_count++;
         endcase
      endfunction

      function void compare_field(string field, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
            mismatches++;
         end
      endfunction

      // Compare one result transfer against the oldest owed result.
      function void check_response(queue_result_type got);
         queue_result_type want;
         if (owed.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual value %0h list %0h",
                     $time, got.data.value, got.data.list);
            $display("%0t: unexpected result: index %0h status %0h last %0h",
                     $time, got.data.index, got.status, got.last);
            mismatches++;
            return;
         end
         want = owed.pop_front();
         results_checked++;
         compare_field("value", want.data.value, got.data.value);
         compare_field("list", 32'(want.data.list), 32'(got.data.list));
         compare_field("index", 32'(want.data.index), 32'(got.data.index));
         compare_field("status", 32'(want.status), 32'(got.status));
         compare_field("last", 32'(want.last), 32'(got.last));
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [CW-1:0]         req_cmd;
   logic signed [VW-1:0]  req_value;
   logic [LW-1:0]         req_source_list;
   logic [IDX-1:0]        req_element_index;
   logic                  rsp_valid;
   logic signed [VW-1:0]  rsp_out_value;
   logic [LW-1:0]         rsp_out_list;
   logic [IDX-1:0]        rsp_out_index;
   logic [SW-1:0]         rsp_status;
   logic                  rsp_last;

   sorted_queue_shadow shadow = new();
   int idle_pct;
   int counted_items;
   int stall_cycles;

   kway_merge_sorted_queue #(
      .QUEUE_DEPTH(DEPTH),
      .INDEX_BITS (IDX)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_cmd          (req_cmd),
      .req_value        (req_value),
      .req_source_list  (req_source_list),
      .req_element_index(req_element_index),
      .rsp_valid        (rsp_valid),
      .rsp_out_value    (rsp_out_value),
      .rsp_out_list     (rsp_out_list),
      .rsp_out_index    (rsp_out_index),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last)
   );

   // Clock with a period of 10.
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Check every result transfer.
   always @(posedge clock) begin
      queue_result_type got;
      if (!reset && rsp_valid) begin
         got.data.value = rsp_out_value;
         got.data.list  = rsp_out_list;
         got.data.index = rsp_out_index;
         got.status     = rsp_status;
         got.last       = rsp_last;
         shadow.check_response(got);
      end
   end

   // Give up when neither channel has moved a transfer for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // Present one command, hold it until the transfer, then maybe leave a gap.
   task automatic issue(logic [CW-1:0] cmd, logic signed [VW-1:0] value,
                        logic [LW-1:0] list, logic [IDX-1:0] index);
      req_cmd           <= cmd;
      req_value         <= value;
      req_source_list   <= list;
      req_element_index <= index;
      start             <= 1'b1;
      do @(posedge clock); while (busy);
      shadow.apply_command(cmd, value, list, index);
      if (cmd != CMD_UNUSED) counted_items++;
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // Hold off the sender until every owed result has come back.
   task automatic wait_for_results();
      start <= 1'b0;
      do @(posedge clock); while (shadow.pending() != 0);
   endtask

   // Keys: mostly a narrow band to force ties, some full range, some extremes.
   function automatic logic signed [VW-1:0] pick_value();
      int sel;
      sel = $urandom_range(9);
      if (sel == 0) return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      if (sel <= 3) return $urandom();
      return $signed($urandom_range(32)) - 16;
   endfunction

   function automatic logic [CW-1:0] pick_cmd(int insert_pct, int pop_pct);
      int r;
      r = $urandom_range(99);
      if (r < 2) return CMD_UNUSED;
      if (r < 2 + insert_pct) return kwmq_pkg::CMD_INSERT;
      if (r < 2 + insert_pct + pop_pct) return kwmq_pkg::CMD_POP;
      return kwmq_pkg::CMD_DUMP;
   endfunction

   initial begin
      int mode;
      int round_len;
      int first_round;
      logic [CW-1:0] cmd;
      reset             = 1'b1;
      start             = 1'b0;
      req_cmd           = kwmq_pkg::CMD_INSERT;
      req_value         = '0;
      req_source_list   = '0;
      req_element_index = '0;
      idle_pct          = 33;
      counted_items     = 0;
      stall_cycles      = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty queue, extreme fields, ties, ignored command, full drain.
      issue(kwmq_pkg::CMD_POP, 0, '0, '0);
      issue(kwmq_pkg::CMD_DUMP, 0, '0, '0);
      issue(CMD_UNUSED, 32'sh12345678, 5'd9, 16'h00ff);
      issue(kwmq_pkg::CMD_INSERT, 32'sh7fffffff, 5'd31, 16'hffff);
      issue(kwmq_pkg::CMD_INSERT, 32'sh80000000, 5'd0, 16'h0000);
      issue(kwmq_pkg::CMD_INSERT, 0, 5'd5, 16'd100);
      issue(kwmq_pkg::CMD_INSERT, -1, 5'd7, 16'd1);
      issue(kwmq_pkg::CMD_INSERT, 5, 5'd1, 16'd2);
      issue(kwmq_pkg::CMD_INSERT, 5, 5'd2, 16'd3);
      issue(kwmq_pkg::CMD_INSERT, 5, 5'd3, 16'd4);
      issue(kwmq_pkg::CMD_DUMP, 0, '0, '0);
      issue(CMD_UNUSED, -1, 5'd31, 16'hffff);
      repeat (3) issue(kwmq_pkg::CMD_POP, 0, '0, '0);
      issue(kwmq_pkg::CMD_DUMP, 0, '0, '0);
      issue(kwmq_pkg::CMD_INSERT, 32'sh7fffffff, 5'd0, 16'h5555);
      issue(kwmq_pkg::CMD_DUMP, 0, '0, '0);
      repeat (6) issue(kwmq_pkg::CMD_POP, 0, '0, '0);
      wait_for_results();

      // Random rounds of fill, drain and mixed merge traffic.
      counted_items = 0;
      first_round   = 1;
      while (counted_items < RANDOM_ITEMS) begin
         if (idle_pct == 33 && counted_items >= RANDOM_ITEMS / 3) begin
            wait_for_results();
            idle_pct = 65;
         end else if (idle_pct == 65 && counted_items >= 2 * RANDOM_ITEMS / 3) begin
            wait_for_results();
            idle_pct = 0;
         end
         // The first round fills the queue past its depth.
         mode      = first_round ? 0 : $urandom_range(2);
         round_len = first_round ? 40 : $urandom_range(10, 40);
         repeat (round_len) begin
            case (mode)
               0: cmd = first_round ? kwmq_pkg::CMD_INSERT : pick_cmd(83, 10);
               1: cmd = pick_cmd(10, 83);
               default: cmd = pick_cmd(46, 44);
            endcase
            issue(cmd, pick_value(), LW'($urandom_range(31)), IDX'($urandom()));
         end
         first_round = 0;
      end

      // Let the last results arrive, then watch for strays.
      start <= 1'b0;
      while (shadow.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Covered %0d inserts, %0d pops, %0d dumps and %0d ignored commands.",
               shadow.insert_count, shadow.pop_count, shadow.dump_count,
               shadow.ignored_count);
      $display("Checked %0d results, including %0d full and %0d empty reports.",
               shadow.results_checked, shadow.full_seen, shadow.empty_seen);
      if (shadow.mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule

@@ filelist.f @@
rtl/core/kwmq_pkg.sv
rtl/core/kwmq_cell.sv
rtl/core/kway_merge_sorted_queue.sv
tb/tb_kway_merge_sorted_queue.sv
